### rtl/smebf_pkg.sv
package smebf_pkg;

   // Label and position geometry
   localparam int unsigned NUM_LABELS = 64;
   localparam int unsigned LABEL_W    = 6;
   localparam int unsigned POS_W      = 16;
   localparam logic [POS_W-1:0] POS_TOP = 16'hFFFF;

   // Membership masks
   localparam int unsigned SET_W = 64;

   // Configuration port geometry: three 64-bit registers at 8-byte stride
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned REG_IDX_W  = 2;

   // Register indexes
   localparam logic [REG_IDX_W-1:0] REG_START_SET  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_MIDDLE_SET = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_END_SET    = 2'd2;

   // Classification queue geometry
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = 1;
   localparam int unsigned QCNT_W      = 2;

   typedef struct packed {
      logic [SET_W-1:0] start_set;
      logic [SET_W-1:0] middle_set;
      logic [SET_W-1:0] end_set;
   } sets_type;

   // One classified label as it travels from front to back
   typedef struct packed {
      logic is_start;
      logic is_middle;
      logic is_end;
      logic last;
   } item_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Labels at or above NUM_LABELS belong to no set
   function automatic logic in_set(input logic [SET_W-1:0] set,
                                   input logic [LABEL_W-1:0] label);
      logic hit;
      hit = (32'(label) < NUM_LABELS) && set[label];
      return hit;
   endfunction

endpackage

### rtl/smebf_channels.sv
interface smebf_req_if;
   import smebf_pkg::*;

   logic               valid;
   logic               ready;
   logic [LABEL_W-1:0] path_state;
   logic               last_of_path;

   modport source (output valid, path_state, last_of_path, input ready);
   modport sink   (input valid, path_state, last_of_path, output ready);
endinterface

interface smebf_rsp_if;
   import smebf_pkg::*;

   logic             valid;
   logic             ready;
   logic [POS_W-1:0] block_first;
   logic [POS_W-1:0] block_last;

   modport source (output valid, block_first, block_last, input ready);
   modport sink   (input valid, block_first, block_last, output ready);
endinterface

### rtl/smebf_csr.sv
module smebf_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [smebf_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [smebf_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [smebf_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                              pready,
   output smebf_pkg::sets_type               sets
);
   import smebf_pkg::*;

   sets_type             sets_ff;
   sets_type             sets_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:CSR_ADDR_W-REG_IDX_W];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign sets    = sets_ff;

   // Decode the write; unknown indexes are dropped
   always_comb begin
      sets_in = sets_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_START_SET:  sets_in.start_set  = pwdata;
            REG_MIDDLE_SET: sets_in.middle_set = pwdata;
            REG_END_SET:    sets_in.end_set    = pwdata;
            default:        sets_in = sets_ff;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         REG_START_SET:  prdata = sets_ff.start_set;
         REG_MIDDLE_SET: prdata = sets_ff.middle_set;
         REG_END_SET:    prdata = sets_ff.end_set;
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sets_ff <= '0;
      end else begin
         sets_ff <= sets_in;
      end
   end

endmodule

### rtl/smebf_front.sv
module smebf_front (
   smebf_req_if.sink                   req,
   input  smebf_pkg::sets_type         sets,
   input  smebf_pkg::queue_status_type qstat,
   output logic                        push,
   output smebf_pkg::item_type         push_item
);
   import smebf_pkg::*;

   // Accept whenever the queue has room
   assign req.ready = !qstat.full;
   assign push      = req.valid && !qstat.full;

   // Classify the label against the three masks
   always_comb begin
      push_item.is_start  = in_set(sets.start_set,  req.path_state);
      push_item.is_middle = in_set(sets.middle_set, req.path_state);
      push_item.is_end    = in_set(sets.end_set,    req.path_state);
      push_item.last      = req.last_of_path;
   end

endmodule

### rtl/smebf_queue.sv
module smebf_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  smebf_pkg::item_type         push_item,
   input  logic                        pop,
   output smebf_pkg::item_type         head_item,
   output smebf_pkg::queue_status_type qstat
);
   import smebf_pkg::*;

   item_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head_item   = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/smebf_back.sv
module smebf_back (
   input  logic                        clock,
   input  logic                        reset,
   input  smebf_pkg::item_type         head_item,
   input  smebf_pkg::queue_status_type qstat,
   output logic                        pop,
   smebf_rsp_if.source                 rsp
);
   import smebf_pkg::*;

   logic             inside_ff;
   logic             inside_in;
   logic             middle_ff;
   logic             middle_in;
   logic             end_ff;
   logic             end_in;
   logic [POS_W-1:0] open_start_ff;
   logic [POS_W-1:0] open_start_in;
   logic [POS_W-1:0] position_ff;
   logic [POS_W-1:0] position_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [POS_W-1:0] first_ff;
   logic [POS_W-1:0] last_ff;
   logic             report;
   logic [POS_W-1:0] last_pos;
   logic             out_free;

   // Take the next label when the output register can hold a result
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign pop      = !qstat.empty && out_free;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.block_first = first_ff;
   assign rsp.block_last  = last_ff;

   // Closing position of the block, clamped to its start
   always_comb begin
      last_pos = (position_ff != '0) ? position_ff - 1'b1 : '0;
      if (last_pos < open_start_ff) begin
         last_pos = open_start_ff;
      end
   end

   // Block tracking
   always_comb begin
      inside_in     = inside_ff;
      middle_in     = middle_ff;
      end_in        = end_ff;
      open_start_in = open_start_ff;
      position_in   = position_ff;
      report        = 1'b0;
      if (pop) begin
         if (inside_ff) begin
            if (head_item.is_middle) begin
               middle_in = 1'b1;
            end else if ((middle_ff || end_ff) && head_item.is_end) begin
               end_in = 1'b1;
            end else begin
               if (end_ff) begin
                  report = 1'b1;
                  end_in = 1'b0;
               end
               middle_in = 1'b0;
               if (head_item.is_start) begin
                  open_start_in = position_ff;
               end else begin
                  inside_in = 1'b0;
               end
            end
         end else if (head_item.is_start) begin
            open_start_in = position_ff;
            inside_in     = 1'b1;
         end
         // Drop any open block at the end of a path
         if (head_item.last) begin
            position_in = '0;
            inside_in   = 1'b0;
            middle_in   = 1'b0;
            end_in      = 1'b0;
         end else if (position_ff < POS_TOP) begin
            position_in = position_ff + 1'b1;
         end
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (report) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff     <= 1'b0;
         middle_ff     <= 1'b0;
         end_ff        <= 1'b0;
         open_start_ff <= '0;
         position_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         inside_ff     <= inside_in;
         middle_ff     <= middle_in;
         end_ff        <= end_in;
         open_start_ff <= open_start_in;
         position_ff   <= position_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Hold the result payload
   always_ff @(posedge clock) begin
      if (report) begin
         first_ff <= open_start_ff;
         last_ff  <= last_pos;
      end
   end

endmodule

### rtl/start_middle_end_block_finder_core.sv
// Channel   Direction  Handshake      Payload
// req_bus   in         valid/ready    path_state[5:0], last_of_path
// rsp_bus   out        valid/ready    block_first[15:0], block_last[15:0]
// csr (APB) in         psel/penable   start_set, middle_set, end_set (64 bits each)
//
// One label per cycle sustained while rsp_bus does not stall; a label is
// classified on acceptance and handled by the tracker after the queue.
// A result appears on rsp_bus the cycle after the tracker takes the label after the block.
// Reset clears the masks, the two-entry queue, the flags and the position.
// Stalls on rsp_bus hold the tracker; the queue fills and then req_bus.ready drops.
module start_middle_end_block_finder_core (
   input  logic                             clock,
   input  logic                             reset,
   smebf_req_if.sink                        req_bus,
   smebf_rsp_if.source                      rsp_bus,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [smebf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [smebf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [smebf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                             pready
);
   import smebf_pkg::*;

   sets_type         sets;
   queue_status_type qstat;
   item_type         push_item;
   item_type         head_item;
   logic             push;
   logic             pop;

   smebf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .sets    (sets)
   );

   smebf_front u_front (
      .req       (req_bus),
      .sets      (sets),
      .qstat     (qstat),
      .push      (push),
      .push_item (push_item)
   );

   smebf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .qstat     (qstat)
   );

   smebf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_item (head_item),
      .qstat     (qstat),
      .pop       (pop),
      .rsp       (rsp_bus)
   );

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
   import smebf_pkg::*;

   // Index past the last register: writes there must be ignored
   localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_LABELS   = 325;

   // Predicts the reported blocks and holds them until the block returns them
   class block_scoreboard;
      typedef struct {
         logic [POS_W-1:0] first;
         logic [POS_W-1:0] last;
      } span_type;

      logic [SET_W-1:0] start_mask, middle_mask, end_mask;
      bit               in_block, mid_seen, end_seen;
      logic [POS_W-1:0] open_pos, pos;
      span_type         spans[$];
      int               errors, labels_seen, blocks_checked;

      function new();
         start_mask  = '0;
         middle_mask = '0;
         end_mask    = '0;
         in_block    = 0;
         mid_seen    = 0;
         end_seen    = 0;
         open_pos    = '0;
         pos         = '0;
      endfunction

      function void write_mask(logic [REG_IDX_W-1:0] idx, logic [SET_W-1:0] val);
         case (idx)
            REG_START_SET:  start_mask  = val;
            REG_MIDDLE_SET: middle_mask = val;
            REG_END_SET:    end_mask    = val;
            default: ;
         endcase
      endfunction

      // Advance the tracker by one accepted label
      function void note_label(logic [LABEL_W-1:0] label, logic last_flag);
         bit               hit_s, hit_m, hit_e;
         logic [POS_W-1:0] lp;
         span_type         sp;
         hit_s = start_mask[label];
         hit_m = middle_mask[label];
         hit_e = end_mask[label];
         labels_seen++;
         if (in_block) begin
            if (hit_m) begin
               mid_seen = 1;
            end else if ((mid_seen || end_seen) && hit_e) begin
               end_seen = 1;
            end else begin
               // close a finished block, clamp its last position to its first
               if (end_seen) begin
                  lp = (pos > 0) ? pos - 1'b1 : '0;
                  if (lp < open_pos) lp = open_pos;
                  sp.first = open_pos;
                  sp.last  = lp;
                  spans.insert(spans.size(), sp);
                  end_seen = 0;
               end
               mid_seen = 0;
               if (hit_s) open_pos = pos;
               else in_block = 0;
            end
         end else if (hit_s) begin
            open_pos = pos;
            in_block = 1;
         end
         // end of path drops any open block; position holds at the ceiling
         if (last_flag) begin
            pos      = '0;
            in_block = 0;
            mid_seen = 0;
            end_seen = 0;
         end else if (pos != POS_TOP) begin
            pos = pos + 1'b1;
         end
      endfunction

      function void check_block(logic [POS_W-1:0] first, logic [POS_W-1:0] last);
         span_type sp;
         blocks_checked++;
         if (spans.size() == 0) begin
            errors++;
            $display("%0t: unexpected block: expected none, actual first=%0d last=%0d",
                     $time, first, last);
         end else begin
            sp = spans.pop_front();
            if (first !== sp.first) begin
               errors++;
               $display("%0t: block_first mismatch: expected %0d, actual %0d",
                        $time, sp.first, first);
            end
            if (last !== sp.last) begin
               errors++;
               $display("%0t: block_last mismatch: expected %0d, actual %0d",
                        $time, sp.last, last);
            end
         end
      endfunction

      function int pending();
         return spans.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;

   smebf_req_if req_bus ();
   smebf_rsp_if rsp_bus ();

   block_scoreboard sb;
   bit tx_idle, rx_idle;
   int hold_cycles;
   int csr_writes;
   int idle_count;

   start_middle_end_block_finder_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Offer one label, after a random gap when tx_idle is set, and hold it until accepted
   task automatic send_label(logic [LABEL_W-1:0] label, logic last_flag);
      int gap;
      gap = tx_idle ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.path_state   <= label;
      req_bus.last_of_path <= last_flag;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      sb.note_label(label, last_flag);
   endtask

   // Wait for every expected block, then let the pipeline empty
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // APB write: setup, then access until pready
   task automatic csr_write(logic [REG_IDX_W-1:0] idx, logic [SET_W-1:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      sb.write_mask(idx, val);
      csr_writes++;
   endtask

   task automatic load_masks(logic [SET_W-1:0] s, logic [SET_W-1:0] m, logic [SET_W-1:0] e);
      csr_write(REG_START_SET, s);
      csr_write(REG_MIDDLE_SET, m);
      csr_write(REG_END_SET, e);
   endtask

   function automatic logic [LABEL_W-1:0] pick_label(logic [SET_W-1:0] mask);
      logic [LABEL_W-1:0] l;
      l = LABEL_W'($urandom_range(0, 63));
      for (int t = 0; t < 64 && !mask[l]; t++) l = LABEL_W'($urandom_range(0, 63));
      return l;
   endfunction

   // Mostly well-formed blocks with random content, the rest noise
   task automatic send_random(int count);
      int sent, nm, ne;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 3) == 0) begin
            send_label(LABEL_W'($urandom_range(0, 63)), $urandom_range(0, 15) == 0);
            sent++;
         end else begin
            send_label(pick_label(sb.start_mask), 1'b0);
            nm = $urandom_range(0, 3);
            ne = $urandom_range(0, 3);
            for (int i = 0; i < nm; i++) send_label(pick_label(sb.middle_mask), 1'b0);
            for (int i = 0; i < ne; i++) send_label(pick_label(sb.end_mask), 1'b0);
            send_label(LABEL_W'($urandom_range(0, 63)), $urandom_range(0, 9) == 0);
            sent += nm + ne + 2;
         end
      end
   endtask

   // Take results, stalling a random number of cycles after each one when rx_idle is set
   initial begin
      int wait_left;
      wait_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            sb.check_block(rsp_bus.block_first, rsp_bus.block_last);
            wait_left = rx_idle ? $urandom_range(0, 18) : 0;
         end
         if (hold_cycles > 0) begin
            wait_left   = hold_cycles;
            hold_cycles = 0;
         end
         if (wait_left > 0) begin
            rsp_bus.ready <= 1'b0;
            wait_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Abort when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (psel && penable && pready)) begin
         idle_count <= 0;
      end else if (idle_count >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, no transaction for %0d cycles", $time, idle_count);
         $display("[start_middle_end_block_finder_core] ERROR");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   initial begin
      logic [SET_W-1:0] a, b, c;
      sb                   = new();
      hold_cycles          = 0;
      csr_writes           = 0;
      idle_count           = 0;
      tx_idle              = 1;
      rx_idle              = 1;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.path_state   = '0;
      req_bus.last_of_path = 1'b0;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty masks after reset: nothing may be reported
      send_label(6'd0, 1'b0);
      send_label(6'd63, 1'b0);
      send_label(6'd21, 1'b0);
      send_label(6'd42, 1'b1);
      settle();

      // Start 1/63, middle 2/62, end 3/0; the spare index must change nothing
      load_masks((64'd1 << 1) | (64'd1 << 63), (64'd1 << 2) | (64'd1 << 62),
                 (64'd1 << 3) | 64'd1);
      csr_write(REG_SPARE, '1);

      // Plain block, reported on the following label
      send_label(6'd1, 1'b0);  send_label(6'd2, 1'b0);
      send_label(6'd3, 1'b0);  send_label(6'd5, 1'b0);
      // End without a middle does not qualify
      send_label(6'd1, 1'b0);  send_label(6'd3, 1'b0);  send_label(6'd5, 1'b0);
      // Restart inside a block, then a block closed by a new start
      send_label(6'd1, 1'b0);  send_label(6'd63, 1'b0); send_label(6'd62, 1'b0);
      send_label(6'd0, 1'b0);  send_label(6'd3, 1'b0);  send_label(6'd1, 1'b0);
      // Open block dropped at the end of the path
      send_label(6'd2, 1'b0);  send_label(6'd3, 1'b1);
      // Block reported on the last label of a path
      send_label(6'd63, 1'b0); send_label(6'd2, 1'b0);  send_label(6'd0, 1'b0);
      send_label(6'd5, 1'b1);
      settle();

      // Random phases over several mask settings
      for (int p = 0; p < 5; p++) begin
         a = {$urandom, $urandom};
         b = {$urandom, $urandom};
         c = {$urandom, $urandom};
         case (p)
            0: load_masks(a, b, c);
            1: load_masks('1, a & b, '1);
            2: load_masks('1, '1, '1);
            3: load_masks(a & b, b & c, a & c);
            default: load_masks(a | b, b & c, a | c);
         endcase
         tx_idle = (p != 1);
         rx_idle = (p != 3);
         if (p == 4) begin
            send_random(100);
            hold_cycles = 400;
         end
         send_random(PHASE_LABELS);
         settle();
      end

      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Run covered %0d labels and %0d reported blocks over %0d register writes,",
               sb.labels_seen, sb.blocks_checked, csr_writes);
      $display("including empty and full masks, a spare register index and a long output stall.");
      if (sb.errors == 0) begin
         $display("[start_middle_end_block_finder_core] OK");
      end else begin
         $display("[start_middle_end_block_finder_core] ERROR");
      end
      $finish;
   end

endmodule
